>>> hw/rtl/pnn_pkg.sv
// ----------------------------------------------------------------------------
// pnn_pkg
// Shared types, character codes and the country-code prefix table for the
// phone number normalizer.
// ----------------------------------------------------------------------------
package pnn_pkg;

  localparam int MAX_DIGITS_DEF = 15;
  localparam int OUT_DIGITS     = 15;
  localparam int CC_BCD_W       = 12;
  localparam int CC_LEN_W       = 2;
  localparam int CFG_IDX_W      = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_CC_BCD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_CC_LEN = 1'd1;

  localparam logic [CC_BCD_W-1:0] DEFAULT_CC_BCD_RST = 12'h033;
  localparam logic [CC_LEN_W-1:0] DEFAULT_CC_LEN_RST = 2'd2;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // code group length saturates here
  localparam logic [2:0] GRP_LEN_MAX = 3'd4;
  localparam logic [1:0] PLUS_MAX    = 2'd2;
  // country code whose national part may not start with zero
  localparam logic [3:0] FR_CC_HI = 4'd3;
  localparam logic [3:0] FR_CC_LO = 4'd3;
  localparam int         MIN_NATIONAL = 3;

  typedef enum logic [2:0] {
    PH_START,
    PH_PAREN_PRE,
    PH_PAREN_CODE,
    PH_INTL_PRE,
    PH_INTL_BLANK,
    PH_INTL_CODE,
    PH_REST
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_NUMBER = 3'd1,
    ST_BAD_CHAR   = 3'd2,
    ST_INCOMPLETE = 3'd3,
    ST_BAD_CODE   = 3'd4
  } status_e;

  typedef struct packed {
    phase_e      phase;
    logic [2:0]  grp_len;
    logic [1:0]  plus_cnt;
    logic        use_dflt;
    status_e     err;
  } parse_ctl_t;

  localparam parse_ctl_t CTL_RST = '{PH_START, 3'd0, 2'd0, 1'b0, ST_OK};

  typedef struct packed {
    status_e    st;
    logic [1:0] len;
  } lookup_t;

  // prefix table: n is the number of digits on hand, up to three
  function automatic lookup_t code_lookup(input logic [3:0] a, input logic [3:0] b,
                                          input logic [1:0] n);
    lookup_t r;
    logic    two;
    r.st  = ST_OK;
    r.len = 2'd0;
    two   = 1'b0;
    if (n == 2'd0) begin
      r.st = ST_INCOMPLETE;
    end else if (a > 4'd9) begin
      r.st = ST_BAD_CHAR;
    end else if (a == 4'd0) begin
      r.st = ST_BAD_CODE;
    end else if (a == 4'd1 || a == 4'd7) begin
      r.len = 2'd1;
    end else if (n < 2'd2) begin
      r.st = ST_INCOMPLETE;
    end else if (b > 4'd9) begin
      r.st = ST_BAD_CHAR;
    end else begin
      unique case (a)
        4'd2:    two = (b == 4'd0 || b == 4'd7);
        4'd3:    two = (b <= 4'd4 || b == 4'd6 || b == 4'd9);
        4'd4:    two = (b != 4'd2);
        4'd5:    two = (b >= 4'd1 && b <= 4'd8);
        4'd6:    two = (b <= 4'd6);
        4'd8:    two = (b == 4'd1 || b == 4'd2 || b == 4'd4 || b == 4'd6);
        4'd9:    two = (b <= 4'd5 || b == 4'd8);
        default: two = 1'b0;
      endcase
      if (two) begin
        r.len = 2'd2;
      end else if (n < 2'd3) begin
        r.st = ST_INCOMPLETE;
      end else begin
        r.len = 2'd3;
      end
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/pnn_finish.sv
// ----------------------------------------------------------------------------
// pnn_finish
// End-of-number check: resolves the country code, checks the lengths and
// assembles the E.164 digit string from the parse state.
// ----------------------------------------------------------------------------
module pnn_finish #(
  parameter int MAX_DIGITS = pnn_pkg::MAX_DIGITS_DEF,
  localparam int DEPTH = MAX_DIGITS + 1,
  localparam int CW    = $clog2(MAX_DIGITS + 2)
) (
  input  pnn_pkg::parse_ctl_t              ctl_i,
  input  logic [CW-1:0]                    cnt_i,
  input  logic [4*DEPTH-1:0]               store_i,
  input  logic [pnn_pkg::CC_BCD_W-1:0]     dflt_bcd_i,
  input  logic [pnn_pkg::CC_LEN_W-1:0]     dflt_len_i,
  output pnn_pkg::status_e                 status_o,
  output logic [1:0]                       cc_digits_o,
  output logic [3:0]                       digit_count_o,
  output logic [4*pnn_pkg::OUT_DIGITS-1:0] digits_bcd_o
);

  localparam int TW    = CW + 1;
  localparam int SEQ_W = 4 * DEPTH + 12;
  localparam int OUT_W = 4 * pnn_pkg::OUT_DIGITS;

  logic [3:0]        cc0, cc1, cc2;
  logic [1:0]        avail;
  logic              bare;
  logic [2:0]        glen_cap;
  pnn_pkg::lookup_t  lk;
  logic [2:0]        clen_cmp;
  logic [1:0]        nstart;
  logic [TW-1:0]     nlen, total;
  logic [3:0]        nat_first;
  logic [SEQ_W-1:0]  seq1, seq2, seq3, seq;

  assign bare = (ctl_i.phase != pnn_pkg::PH_REST);

  // code digits and how many of them are on hand
  always_comb begin
    cc0      = 4'd0;
    cc1      = 4'd0;
    cc2      = 4'd0;
    glen_cap = 3'd0;
    if (ctl_i.use_dflt) begin
      avail = dflt_len_i;
      unique case (dflt_len_i)
        2'd1: cc0 = dflt_bcd_i[3:0];
        2'd2: begin
          cc0 = dflt_bcd_i[7:4];
          cc1 = dflt_bcd_i[3:0];
        end
        2'd3: begin
          cc0 = dflt_bcd_i[11:8];
          cc1 = dflt_bcd_i[7:4];
          cc2 = dflt_bcd_i[3:0];
        end
        default: ;
      endcase
    end else begin
      if (bare) begin
        glen_cap = (cnt_i >= CW'(3)) ? 3'd3 : 3'(cnt_i);
      end else begin
        glen_cap = (ctl_i.grp_len >= 3'd3) ? 3'd3 : ctl_i.grp_len;
      end
      avail = glen_cap[1:0];
      if (avail >= 2'd1) cc0 = store_i[3:0];
      if (avail >= 2'd2) cc1 = store_i[7:4];
      if (avail == 2'd3) cc2 = store_i[11:8];
    end
  end

  assign lk = pnn_pkg::code_lookup(cc0, cc1, avail);

  always_comb begin
    if (ctl_i.use_dflt) begin
      clen_cmp = {1'b0, dflt_len_i};
    end else if (bare) begin
      clen_cmp = {1'b0, lk.len};
    end else begin
      clen_cmp = ctl_i.grp_len;
    end
  end

  assign nstart = ctl_i.use_dflt ? 2'd0 : lk.len;
  assign nlen   = {1'b0, cnt_i} - TW'(nstart);
  assign total  = nlen + TW'(lk.len);

  always_comb begin
    unique case (nstart)
      2'd0:    nat_first = store_i[3:0];
      2'd1:    nat_first = store_i[7:4];
      2'd2:    nat_first = store_i[11:8];
      default: nat_first = store_i[15:12];
    endcase
  end

  // digit sequence, first digit in the low nibble
  assign seq1 = SEQ_W'({store_i, cc0});
  assign seq2 = SEQ_W'({store_i, cc1, cc0});
  assign seq3 = {store_i, cc2, cc1, cc0};

  always_comb begin
    if (ctl_i.use_dflt) begin
      unique case (lk.len)
        2'd1:    seq = seq1;
        2'd2:    seq = seq2;
        2'd3:    seq = seq3;
        default: seq = SEQ_W'(store_i);
      endcase
    end else begin
      seq = SEQ_W'(store_i);
    end
  end

  always_comb begin
    status_o      = pnn_pkg::ST_OK;
    cc_digits_o   = 2'd0;
    digit_count_o = 4'd0;
    digits_bcd_o  = '0;
    priority if (ctl_i.err != pnn_pkg::ST_OK) begin
      status_o = ctl_i.err;
    end else if (ctl_i.phase == pnn_pkg::PH_START || ctl_i.phase == pnn_pkg::PH_PAREN_PRE ||
                 ctl_i.phase == pnn_pkg::PH_PAREN_CODE) begin
      status_o = pnn_pkg::ST_INCOMPLETE;
    end else if (lk.st != pnn_pkg::ST_OK) begin
      status_o = lk.st;
    end else if ({1'b0, lk.len} != clen_cmp) begin
      status_o = pnn_pkg::ST_BAD_CODE;
    end else if (nlen < TW'(pnn_pkg::MIN_NATIONAL)) begin
      status_o = pnn_pkg::ST_BAD_NUMBER;
    end else if (total > TW'(MAX_DIGITS)) begin
      status_o = pnn_pkg::ST_BAD_NUMBER;
    end else if (lk.len == 2'd2 && cc0 == pnn_pkg::FR_CC_HI && cc1 == pnn_pkg::FR_CC_LO &&
                 nat_first == 4'd0) begin
      status_o = pnn_pkg::ST_BAD_NUMBER;
    end else begin
      cc_digits_o   = lk.len;
      digit_count_o = (total > TW'(pnn_pkg::OUT_DIGITS)) ? 4'd15 : total[3:0];
      for (int k = 0; k < pnn_pkg::OUT_DIGITS; k++) begin
        if (TW'(k) < total) begin
          digits_bcd_o[OUT_W-4-4*k +: 4] = seq[4*k +: 4];
        end
      end
    end
  end

endmodule

>>> hw/rtl/phone_number_normalizer.sv
// ----------------------------------------------------------------------------
// phone_number_normalizer
// Character stream in, one E.164 result or error per number out.
//
//   channel   dir  beat contents
//   s_axis    in   tdata[7:0] char_code, tlast is_last
//   m_axis    out  tdata: status, cc_digits, digit_count, digits_bcd
//   cfg       in   index 0 default_cc_bcd, index 1 default_cc_len
//
// One character per cycle while s_axis_tready is high. Each character is held in
// the input register, where the parser updates its state; when the last character
// advances, the final check runs in the same cycle and the result register is
// loaded. s_axis_tready only drops when a last character waits behind a result
// that is not yet taken. Reset returns the parser to the start of a number and
// loads the default country code 33.
// ----------------------------------------------------------------------------
module phone_number_normalizer #(
  parameter int MAX_DIGITS = pnn_pkg::MAX_DIGITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [7:0] char_code
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [2:0] status, [4:3] cc_digits, [8:5] digit_count, [68:9] digits_bcd
  output logic [71:0]                       m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [pnn_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pnn_pkg::CC_BCD_W-1:0]      cfg_wdata_i
);

  localparam int DEPTH = MAX_DIGITS + 1;
  localparam int CW    = $clog2(MAX_DIGITS + 2);
  localparam int IW    = $clog2(DEPTH);

  logic [pnn_pkg::CC_BCD_W-1:0] dflt_bcd_q;
  logic [pnn_pkg::CC_LEN_W-1:0] dflt_len_q;

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_char_q;
  logic       in_last_q;
  logic       adv;

  pnn_pkg::parse_ctl_t ctl_q, ctl_d, ctl_nxt;
  logic [CW-1:0]       cnt_q, cnt_d, cnt_nxt;
  logic [4*DEPTH-1:0]  store_q, store_d;

  logic   is_dig, is_sep, push, push_code, done;
  pnn_pkg::phase_e ph;

  pnn_pkg::status_e                 fin_status;
  logic [1:0]                       fin_cc;
  logic [3:0]                       fin_cnt;
  logic [4*pnn_pkg::OUT_DIGITS-1:0] fin_bcd;

  logic        out_vld_q, out_vld_d;
  logic [71:0] out_data_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_bcd_q <= pnn_pkg::DEFAULT_CC_BCD_RST;
      dflt_len_q <= pnn_pkg::DEFAULT_CC_LEN_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == pnn_pkg::CFG_DEFAULT_CC_BCD) begin
        dflt_bcd_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == pnn_pkg::CFG_DEFAULT_CC_LEN) begin
        dflt_len_q <= cfg_wdata_i[pnn_pkg::CC_LEN_W-1:0];
      end
    end
  end

  // input register advances unless a last beat is blocked by the result
  assign adv           = in_vld_q && (!in_last_q || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign in_vld_d      = s_axis_tready ? s_axis_tvalid : in_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  assign is_dig = (in_char_q >= pnn_pkg::CH_ZERO) && (in_char_q <= pnn_pkg::CH_NINE);
  assign is_sep = (in_char_q == pnn_pkg::CH_SPACE) || (in_char_q == pnn_pkg::CH_DASH) ||
                  (in_char_q == pnn_pkg::CH_DOT);

  // per-character parser; phases fall through within one character
  always_comb begin
    ctl_nxt   = ctl_q;
    ph        = ctl_q.phase;
    push      = 1'b0;
    push_code = 1'b0;
    done      = 1'b0;
    if (ctl_q.err == pnn_pkg::ST_OK) begin
      if (ph == pnn_pkg::PH_START) begin
        if (in_char_q == pnn_pkg::CH_LPAREN) begin
          ph   = pnn_pkg::PH_PAREN_PRE;
          done = 1'b1;
        end else if (in_char_q == pnn_pkg::CH_ZERO) begin
          ctl_nxt.use_dflt = 1'b1;
          ph               = pnn_pkg::PH_REST;
          done             = 1'b1;
        end else begin
          ph = pnn_pkg::PH_INTL_PRE;
        end
      end
      if (!done && ph == pnn_pkg::PH_PAREN_PRE) begin
        if (ctl_nxt.plus_cnt == 2'd0 && in_char_q == pnn_pkg::CH_SPACE) begin
          done = 1'b1;
        end else if (in_char_q == pnn_pkg::CH_PLUS && ctl_nxt.plus_cnt < pnn_pkg::PLUS_MAX) begin
          ctl_nxt.plus_cnt = ctl_nxt.plus_cnt + 2'd1;
          if (ctl_nxt.plus_cnt == pnn_pkg::PLUS_MAX) ph = pnn_pkg::PH_PAREN_CODE;
          done = 1'b1;
        end else begin
          ph = pnn_pkg::PH_PAREN_CODE;
        end
      end
      if (!done && ph == pnn_pkg::PH_PAREN_CODE) begin
        done = 1'b1;
        if (in_char_q == pnn_pkg::CH_RPAREN) begin
          ph = pnn_pkg::PH_REST;
        end else if (is_dig) begin
          push_code = 1'b1;
        end else if (in_char_q != pnn_pkg::CH_SPACE) begin
          ctl_nxt.err = pnn_pkg::ST_BAD_CHAR;
        end
      end
      if (!done && ph == pnn_pkg::PH_INTL_PRE) begin
        if (in_char_q == pnn_pkg::CH_PLUS && ctl_nxt.plus_cnt < pnn_pkg::PLUS_MAX) begin
          ctl_nxt.plus_cnt = ctl_nxt.plus_cnt + 2'd1;
          if (ctl_nxt.plus_cnt == pnn_pkg::PLUS_MAX) ph = pnn_pkg::PH_INTL_BLANK;
          done = 1'b1;
        end else begin
          ph = pnn_pkg::PH_INTL_BLANK;
        end
      end
      if (!done && ph == pnn_pkg::PH_INTL_BLANK) begin
        if (in_char_q == pnn_pkg::CH_SPACE) begin
          done = 1'b1;
        end else begin
          ph = pnn_pkg::PH_INTL_CODE;
        end
      end
      if (!done && ph == pnn_pkg::PH_INTL_CODE) begin
        done = 1'b1;
        if (is_sep) begin
          ph = pnn_pkg::PH_REST;
        end else if (is_dig) begin
          push_code = 1'b1;
        end else begin
          ctl_nxt.err = pnn_pkg::ST_BAD_CHAR;
        end
      end
      if (!done && ph == pnn_pkg::PH_REST) begin
        if (is_dig) begin
          push = 1'b1;
        end else if (!is_sep) begin
          ctl_nxt.err = pnn_pkg::ST_BAD_CHAR;
        end
      end
      ctl_nxt.phase = ph;
    end
    if (push_code && ctl_q.grp_len < pnn_pkg::GRP_LEN_MAX) begin
      ctl_nxt.grp_len = ctl_q.grp_len + 3'd1;
    end
  end

  // digit store write, count saturates one past the limit
  always_comb begin
    cnt_nxt = cnt_q;
    store_d = store_q;
    if ((push || push_code) && cnt_q < CW'(DEPTH)) begin
      store_d[4*cnt_q[IW-1:0] +: 4] = in_char_q[3:0];
      cnt_nxt                       = cnt_q + CW'(1);
    end
  end

  pnn_finish #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_finish (
    .ctl_i         (ctl_nxt),
    .cnt_i         (cnt_nxt),
    .store_i       (store_d),
    .dflt_bcd_i    (dflt_bcd_q),
    .dflt_len_i    (dflt_len_q),
    .status_o      (fin_status),
    .cc_digits_o   (fin_cc),
    .digit_count_o (fin_cnt),
    .digits_bcd_o  (fin_bcd)
  );

  // parse state returns to start after the last character
  always_comb begin
    ctl_d = ctl_q;
    cnt_d = cnt_q;
    if (adv) begin
      if (in_last_q) begin
        ctl_d = pnn_pkg::CTL_RST;
        cnt_d = '0;
      end else begin
        ctl_d = ctl_nxt;
        cnt_d = cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= pnn_pkg::CTL_RST;
      cnt_q <= '0;
    end else begin
      ctl_q <= ctl_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      store_q <= store_d;
    end
  end

  // result register
  always_comb begin
    if (adv && in_last_q) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_last_q) begin
      out_data_q <= {3'b000, fin_bcd, fin_cnt, fin_cc, fin_status};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // an error result carries no digits
  a_err_no_digits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2:0] != pnn_pkg::ST_OK) |->
      (m_axis_tdata[68:3] == '0))
    else $error("error result carries digits");

  // a good result has a code and at least three national digits
  a_ok_lengths : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2:0] == pnn_pkg::ST_OK) |->
      (m_axis_tdata[4:3] != 2'd0 && m_axis_tdata[8:5] >= {2'b00, m_axis_tdata[4:3]} + 4'd3))
    else $error("good result with bad lengths");

  // the first bad character sticks until the number ends
  a_err_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q.err != pnn_pkg::ST_OK && !(adv && in_last_q)) |=> (ctl_q.err == $past(ctl_q.err)))
    else $error("sticky error lost");

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("digit count past saturation");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for phone_number_normalizer. Phone number texts, some
// hand-picked and most generated in every form the parser knows, go in one
// character per beat. A scoreboard parses the same characters, predicts the
// E.164 result of each number and compares every output beat field by field,
// across several default country code settings and with random stalls.
// ----------------------------------------------------------------------------
module tb;
  import pnn_pkg::*;

  localparam int          MAX_DIG     = MAX_DIGITS_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;

  // same layout as m_axis_tdata[68:0]
  typedef struct packed {
    logic [59:0] bcd;
    logic [3:0]  count;
    logic [1:0]  cc_len;
    status_e     status;
  } e164_t;

  class e164_scoreboard;
    logic [CC_BCD_W-1:0] dflt_bcd;
    logic [CC_LEN_W-1:0] dflt_len;
    phase_e      phase;
    logic [3:0]  digits [MAX_DIG+1];
    int unsigned n_digits;
    int unsigned grp_len;
    int unsigned plus_cnt;
    bit          use_dflt;
    status_e     err;
    e164_t       expected_q[$];
    int unsigned fail_cnt;

    function new();
      dflt_bcd = DEFAULT_CC_BCD_RST;
      dflt_len = DEFAULT_CC_LEN_RST;
      fail_cnt = 0;
      restart();
    endfunction

    function void restart();
      phase    = PH_START;
      n_digits = 0;
      grp_len  = 0;
      plus_cnt = 0;
      use_dflt = 1'b0;
      err      = ST_OK;
    endfunction

    function void set_default(logic [CC_BCD_W-1:0] bcd, logic [CC_LEN_W-1:0] len);
      dflt_bcd = bcd;
      dflt_len = len;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // country code prefix table, n digits on hand
    function status_e prefix_lookup(logic [3:0] d0, logic [3:0] d1, int unsigned n,
                                    output int unsigned len);
      logic [9:0] two_mask;
      len = 0;
      if (n == 0) return ST_INCOMPLETE;
      if (d0 > 4'd9) return ST_BAD_CHAR;
      if (d0 == 4'd0) return ST_BAD_CODE;
      if (d0 == 4'd1 || d0 == 4'd7) begin
        len = 1;
        return ST_OK;
      end
      if (n < 2) return ST_INCOMPLETE;
      if (d1 > 4'd9) return ST_BAD_CHAR;
      // bit b set: second digit b closes a two-digit code
      case (d0)
        4'd2:    two_mask = 10'h081;
        4'd3:    two_mask = 10'h25F;
        4'd4:    two_mask = 10'h3FB;
        4'd5:    two_mask = 10'h1FE;
        4'd6:    two_mask = 10'h07F;
        4'd8:    two_mask = 10'h056;
        4'd9:    two_mask = 10'h13F;
        default: two_mask = 10'h000;
      endcase
      if (two_mask[d1]) begin
        len = 2;
        return ST_OK;
      end
      if (n < 3) return ST_INCOMPLETE;
      len = 3;
      return ST_OK;
    endfunction

    function void store_digit(logic [7:0] c, bit in_code);
      if (n_digits < MAX_DIG + 1) begin
        digits[n_digits] = 4'(c - CH_ZERO);
        n_digits++;
      end
      if (in_code && grp_len < GRP_LEN_MAX) grp_len++;
    endfunction

    function void take_char(logic [7:0] c);
      bit digit;
      bit sep;
      digit = (c >= CH_ZERO && c <= CH_NINE);
      sep   = (c == CH_SPACE || c == CH_DASH || c == CH_DOT);
      if (err != ST_OK) return;
      if (phase == PH_START) begin
        if (c == CH_LPAREN) begin
          phase = PH_PAREN_PRE;
          return;
        end
        if (c == CH_ZERO) begin
          use_dflt = 1'b1;
          phase    = PH_REST;
          return;
        end
        phase = PH_INTL_PRE;
      end
      if (phase == PH_PAREN_PRE) begin
        if (plus_cnt == 0 && c == CH_SPACE) return;
        if (c == CH_PLUS && plus_cnt < PLUS_MAX) begin
          plus_cnt++;
          if (plus_cnt == PLUS_MAX) phase = PH_PAREN_CODE;
          return;
        end
        phase = PH_PAREN_CODE;
      end
      if (phase == PH_PAREN_CODE) begin
        if (c == CH_RPAREN) phase = PH_REST;
        else if (digit) store_digit(c, 1'b1);
        else if (c != CH_SPACE) err = ST_BAD_CHAR;
        return;
      end
      if (phase == PH_INTL_PRE) begin
        if (c == CH_PLUS && plus_cnt < PLUS_MAX) begin
          plus_cnt++;
          if (plus_cnt == PLUS_MAX) phase = PH_INTL_BLANK;
          return;
        end
        phase = PH_INTL_BLANK;
      end
      if (phase == PH_INTL_BLANK) begin
        if (c == CH_SPACE) return;
        phase = PH_INTL_CODE;
      end
      if (phase == PH_INTL_CODE) begin
        if (sep) phase = PH_REST;
        else if (digit) store_digit(c, 1'b1);
        else err = ST_BAD_CHAR;
        return;
      end
      if (digit) store_digit(c, 1'b0);
      else if (!sep) err = ST_BAD_CHAR;
    endfunction

    function e164_t close_number();
      e164_t       r;
      logic [3:0]  cc [3];
      int unsigned clen;
      int unsigned avail;
      int unsigned cc_found;
      int unsigned nat_start;
      int unsigned nat_cnt;
      int unsigned total;
      status_e     st;
      r = '0;
      for (int k = 0; k < 3; k++) cc[k] = 4'd0;
      if (err != ST_OK) begin
        r.status = err;
        return r;
      end
      if (phase == PH_START || phase == PH_PAREN_PRE || phase == PH_PAREN_CODE) begin
        r.status = ST_INCOMPLETE;
        return r;
      end
      if (use_dflt) begin
        clen = dflt_len;
        for (int k = 0; k < clen; k++) cc[k] = dflt_bcd[4*(clen-1-k) +: 4];
        avail     = clen;
        nat_start = 0;
      end else begin
        // no separator closed the group: split where the table says
        clen  = (phase == PH_REST) ? grp_len : n_digits;
        avail = (clen < 3) ? clen : 3;
        for (int k = 0; k < avail; k++) cc[k] = digits[k];
        if (phase != PH_REST) begin
          st = prefix_lookup(cc[0], cc[1], avail, cc_found);
          if (st != ST_OK) begin
            r.status = st;
            return r;
          end
          clen = cc_found;
        end
        nat_start = clen;
      end
      st = prefix_lookup(cc[0], cc[1], avail, cc_found);
      if (st != ST_OK) begin
        r.status = st;
        return r;
      end
      if (cc_found != clen) begin
        r.status = ST_BAD_CODE;
        return r;
      end
      nat_cnt = n_digits - nat_start;
      total   = cc_found + nat_cnt;
      if (nat_cnt < MIN_NATIONAL || total > MAX_DIG) begin
        r.status = ST_BAD_NUMBER;
        return r;
      end
      if (cc_found == 2 && cc[0] == FR_CC_HI && cc[1] == FR_CC_LO &&
          digits[nat_start] == 4'd0) begin
        r.status = ST_BAD_NUMBER;
        return r;
      end
      for (int k = 0; k < total && k < OUT_DIGITS; k++)
        r.bcd[4*(OUT_DIGITS-1-k) +: 4] = (k < cc_found) ? cc[k]
                                                         : digits[nat_start + k - cc_found];
      r.status = ST_OK;
      r.cc_len = 2'(cc_found);
      r.count  = (total < OUT_DIGITS) ? 4'(total) : 4'(OUT_DIGITS);
      return r;
    endfunction

    function void note_char(logic [7:0] c, bit last);
      take_char(c);
      if (last) begin
        expected_q.push_back(close_number());
        restart();
      end
    endfunction

    function void compare_field(string field, logic [59:0] want, logic [59:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h got %0h", $time, field, want, got);
        fail_cnt++;
      end
    endfunction

    function void check_result(logic [71:0] beat);
      e164_t got;
      e164_t want;
      got = e164_t'(beat[68:0]);
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with none expected, got %h", $time, beat);
        fail_cnt++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("cc_digits", want.cc_len, got.cc_len);
      compare_field("digit_count", want.count, got.count);
      compare_field("digits_bcd", want.bcd, got.bcd);
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [71:0]          m_axis_tdata;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = CFG_DEFAULT_CC_BCD;
  logic [CC_BCD_W-1:0]  cfg_wdata_i   = '0;

  e164_scoreboard sb;
  logic [7:0]     text_q[$];
  int unsigned    items_sent    = 0;
  int unsigned    cycle_cnt     = 0;
  bit             calm          = 1'b0;
  bit             sink_hold_req = 1'b0;

  phone_number_normalizer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] pick_sep();
    case ($urandom_range(0, 2))
      0:       return CH_SPACE;
      1:       return CH_DASH;
      default: return CH_DOT;
    endcase
  endfunction

  function automatic int unsigned nat_len();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 2);
      1:       return $urandom_range(13, 18);
      default: return $urandom_range(3, 11);
    endcase
  endfunction

  initial begin : result_sink
    int unsigned idle_left;
    idle_left = 0;
    forever begin
      @(posedge clk_i);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (idle_left != 0) begin
        idle_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(0, 2) == 0) idle_left = pick_gap();
      end
    end
  end

  task automatic send_beat(input logic [7:0] c, input bit last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_char(c, last);
    items_sent++;
    if (!calm && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
  endtask

  task automatic send_chars();
    for (int i = 0; i < text_q.size(); i++) send_beat(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_chars();
  endtask

  function automatic void push_digits(input int unsigned n, input bit with_seps);
    for (int i = 0; i < n; i++) begin
      text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      if (with_seps && $urandom_range(0, 3) == 0) text_q.push_back(pick_sep());
    end
  endfunction

  function automatic void push_code(input logic [11:0] code, input int unsigned n,
                                    input bit spaced);
    logic [3:0] d;
    for (int k = 0; k < n; k++) begin
      d = (k < 3) ? code[11 - 4*k -: 4] : 4'($urandom_range(0, 9));
      text_q.push_back(CH_ZERO + 8'(d));
      if (spaced && $urandom_range(0, 3) == 0) text_q.push_back(CH_SPACE);
    end
  endfunction

  // one phone number text in text_q, mostly well formed
  function automatic void make_number();
    logic [11:0] code;
    int unsigned form;
    int unsigned clen;
    int unsigned cut;
    code[11:8] = ($urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(1, 9));
    code[7:4]  = 4'($urandom_range(0, 9));
    code[3:0]  = 4'($urandom_range(0, 9));
    if (sb.prefix_lookup(code[11:8], code[7:4], 3, clen) != ST_OK ||
        $urandom_range(0, 4) == 0)
      clen = $urandom_range(0, 5);
    form = $urandom_range(0, 19);
    if (form < 6) begin
      repeat ($urandom_range(0, 3)) text_q.push_back(CH_PLUS);
      repeat ($urandom_range(0, 2)) text_q.push_back(CH_SPACE);
      push_code(code, clen, 1'b0);
      text_q.push_back(pick_sep());
      push_digits(nat_len(), 1'b1);
    end else if (form < 12) begin
      text_q.push_back(CH_LPAREN);
      repeat ($urandom_range(0, 1)) text_q.push_back(CH_SPACE);
      repeat ($urandom_range(0, 2)) text_q.push_back(CH_PLUS);
      push_code(code, clen, 1'b1);
      text_q.push_back(CH_RPAREN);
      if ($urandom_range(0, 1) == 0) text_q.push_back(pick_sep());
      push_digits(nat_len(), 1'b1);
    end else if (form < 15) begin
      text_q.push_back(CH_ZERO);
      push_digits(nat_len(), 1'b1);
    end else if (form < 18) begin
      push_code(code, clen, 1'b0);
      push_digits(nat_len(), 1'b0);
    end else begin
      repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
    end
    if (text_q.size() == 0) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    if (form < 18 && $urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, text_q.size());
      while (text_q.size() > cut) void'(text_q.pop_back());
    end
    if ($urandom_range(0, 11) == 0)
      text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
  endfunction

  task automatic random_numbers(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      make_number();
      send_chars();
    end
  endtask

  // block is idle once every number is closed and its result is out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_default_code(input logic [CC_BCD_W-1:0] bcd,
                                  input logic [CC_LEN_W-1:0] len);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_DEFAULT_CC_BCD;
    cfg_wdata_i <= bcd;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_DEFAULT_CC_LEN;
    cfg_wdata_i <= CC_BCD_W'(len);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_default(bcd, len);
  endtask

  initial begin : stimulus
    logic [CC_BCD_W-1:0] bcd_list [7];
    logic [CC_LEN_W-1:0] len_list [7];
    // code 1, extremes, nibble above 9 first / second / third, empty code
    bcd_list = '{12'h001, 12'h999, 12'h000, 12'h0A4, 12'h6E7, 12'h35B, 12'h049};
    len_list = '{2'd1, 2'd3, 2'd1, 2'd2, 2'd3, 2'd3, 2'd0};
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bad character, missing bracket, bare digits, leading zero under 33, plain
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_text("(1");
    send_text("12345");
    send_text("0012");
    send_text("+33 1-2.3");
    random_numbers(200);

    // result side holds off long enough for the input to stall
    drain();
    calm = 1'b1;
    sink_hold_req = 1'b1;
    random_numbers(250);
    calm = 1'b0;

    for (int i = 0; i < 7; i++) begin
      drain();
      set_default_code(bcd_list[i], len_list[i]);
      random_numbers(90);
    end
    for (int i = 0; i < 4; i++) begin
      drain();
      set_default_code(CC_BCD_W'($urandom_range(0, 2457)), CC_LEN_W'($urandom_range(1, 3)));
      random_numbers(90);
    end
    drain();

    if (sb.fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
